// ===== rtl/core/cqs_pkg.sv =====
package cqs_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORD_W = 32;
  localparam int SLOT_W = 3;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    MODE_ENQ     = 2'd0,
    MODE_DEQ     = 2'd1,
    MODE_SEARCH  = 2'd2,
    MODE_DISPLAY = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_ELEMENT   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEQ,
    S_SCAN,
    S_FLUSH
  } state_t;

  function automatic idx_t next_idx(input idx_t i);
    idx_t r;
    if (i == idx_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

  // buffer index masked to the width of the slot field
  function automatic logic [SLOT_W-1:0] slot_of(input idx_t i);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, i};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/cqs_in_if.sv =====
interface cqs_in_if;
  import cqs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic signed [WORD_W-1:0] data_word;

  modport source (output valid, output mode, output data_word, input ready);
  modport sink (input valid, input mode, input data_word, output ready);
endinterface

// ===== rtl/core/cqs_out_if.sv =====
interface cqs_out_if;
  import cqs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic [SLOT_W-1:0]        slot;
  logic signed [WORD_W-1:0] word_out;
  logic                     last;

  modport source (output valid, output status, output slot, output word_out, output last,
                  input ready);
  modport sink (input valid, input status, input slot, input word_out, input last,
                output ready);
endinterface

// ===== rtl/core/cqs_ram.sv =====
module cqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(DEPTH)-1:0]       wr_addr,
  input  logic [WIDTH-1:0]               wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(DEPTH)-1:0]       rd_addr,
  output logic [WIDTH-1:0]               rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/circular_queue_with_search_unit.sv =====
// enqueue, and any request answered on an empty queue: result registered in the exec state
// dequeue: exec issues one registered ram read, and the deq state registers the result
// search and display: one ram read per cycle through the single read port, unless a result
//   waits for the output register; the last display result comes from scan, search from flush
// one request in flight at a time; the next is taken once the last result is registered
// reset empties the queue (head, tail to 0); slot storage is not cleared
module circular_queue_with_search_unit
  import cqs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  cqs_in_if.sink   in_if,
  cqs_out_if.source out_if
);

  state_t state_r, state_nxt;

  idx_t head_r, head_nxt;
  idx_t tail_r, tail_nxt;
  logic empty_r, empty_nxt;
  idx_t idx_r, idx_nxt;

  logic [1:0]        mode_r;
  logic [WORD_W-1:0] word_r;

  logic              pend_valid_r, pend_valid_nxt;
  logic [SLOT_W-1:0] pend_slot_r, pend_slot_nxt;
  logic [WORD_W-1:0] pend_word_r, pend_word_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic              out_last_r, out_last_nxt;

  logic              ram_wr_en;
  idx_t              ram_wr_addr;
  logic              ram_rd_en;
  idx_t              ram_rd_addr;
  logic [WORD_W-1:0] ram_rd_data;

  logic out_free;
  logic accept;
  logic at_tail;
  logic match;
  logic is_disp;
  logic scan_stall;

  assign out_free = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign accept = in_if.valid && in_if.ready;
  assign at_tail = (idx_r == tail_r);
  assign match = (ram_rd_data == word_r);
  assign is_disp = (mode_r == MODE_DISPLAY);
  // a scan step that must hand a result out waits for the output register
  assign scan_stall = (is_disp || (match && pend_valid_r)) && !out_free;

  assign out_if.valid    = out_valid_r;
  assign out_if.status   = out_status_r;
  assign out_if.slot     = out_slot_r;
  assign out_if.word_out = out_word_r;
  assign out_if.last     = out_last_r;

  cqs_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (word_r),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (mode_r == MODE_ENQ || empty_r) begin
          if (out_free) begin
            state_nxt = S_IDLE;
          end
        end else if (mode_r == MODE_DEQ) begin
          state_nxt = S_DEQ;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_DEQ: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!scan_stall && at_tail) begin
          state_nxt = is_disp ? S_IDLE : S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    empty_nxt      = empty_r;
    idx_nxt        = idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_slot_nxt  = pend_slot_r;
    pend_word_nxt  = pend_word_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = tail_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = head_r;

    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_word_nxt   = out_word_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_EXEC: begin
        if (mode_r == MODE_ENQ) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_slot_nxt   = '0;
            out_word_nxt   = '0;
            out_last_nxt   = 1'b1;
            out_status_nxt = ST_OK;
            if (empty_r) begin
              head_nxt    = '0;
              tail_nxt    = '0;
              empty_nxt   = 1'b0;
              ram_wr_en   = 1'b1;
              ram_wr_addr = '0;
            end else if (next_idx(tail_r) == head_r) begin
              out_status_nxt = ST_OVERFLOW;
            end else begin
              tail_nxt    = next_idx(tail_r);
              ram_wr_en   = 1'b1;
              ram_wr_addr = next_idx(tail_r);
            end
          end
        end else if (empty_r) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EMPTY;
            out_slot_nxt   = '0;
            out_word_nxt   = '0;
            out_last_nxt   = 1'b1;
          end
        end else begin
          ram_rd_en      = 1'b1;
          ram_rd_addr    = head_r;
          idx_nxt        = head_r;
          pend_valid_nxt = 1'b0;
        end
      end
      S_DEQ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_slot_nxt   = '0;
          out_word_nxt   = ram_rd_data;
          out_last_nxt   = 1'b1;
          if (head_r == tail_r) begin
            empty_nxt = 1'b1;
            head_nxt  = '0;
            tail_nxt  = '0;
          end else begin
            head_nxt = next_idx(head_r);
          end
        end
      end
      S_SCAN: begin
        if (!scan_stall) begin
          if (is_disp) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_ELEMENT;
            out_slot_nxt   = slot_of(idx_r);
            out_word_nxt   = ram_rd_data;
            out_last_nxt   = at_tail;
          end else if (match) begin
            // a match is held back until the next match or the end of the scan shows whether it is the last
            if (pend_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_FOUND;
              out_slot_nxt   = pend_slot_r;
              out_word_nxt   = pend_word_r;
              out_last_nxt   = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_slot_nxt  = slot_of(idx_r);
            pend_word_nxt  = ram_rd_data;
          end
          if (!at_tail) begin
            idx_nxt     = next_idx(idx_r);
            ram_rd_en   = 1'b1;
            ram_rd_addr = next_idx(idx_r);
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          if (pend_valid_r) begin
            out_status_nxt = ST_FOUND;
            out_slot_nxt   = pend_slot_r;
            out_word_nxt   = pend_word_r;
          end else begin
            out_status_nxt = ST_NOT_FOUND;
            out_slot_nxt   = '0;
            out_word_nxt   = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      empty_r      <= 1'b1;
      idx_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      empty_r      <= empty_nxt;
      idx_r        <= idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_if.mode;
      word_r <= in_if.data_word;
    end
    pend_slot_r  <= pend_slot_nxt;
    pend_word_r  <= pend_word_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_word_r   <= out_word_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

// ===== bench/queue_result_checker.sv =====
`timescale 1ns / 1ps
module queue_result_checker
  import cqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  cqs_in_if           req_mon,
  cqs_out_if          res_mon,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  typedef struct {
    status_t                  status;
    logic [SLOT_W-1:0]        slot;
    logic signed [WORD_W-1:0] word;
    logic                     last;
  } queue_result_t;

  queue_result_t            expected_results[$];
  logic signed [WORD_W-1:0] ring [DEPTH];
  idx_t                     head_idx;
  idx_t                     tail_idx;
  bit                       is_empty;

  function automatic idx_t ring_step(input idx_t i);
    return idx_t'((int'(i) + 1) % DEPTH);
  endfunction

  // each lone result built here has slot 0 and last set
  function automatic queue_result_t lone_result(input status_t s,
                                                input logic signed [WORD_W-1:0] w);
    queue_result_t r;
    r.status = s;
    r.slot   = '0;
    r.word   = w;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic void predict_queue_op(input mode_t m,
                                           input logic signed [WORD_W-1:0] w);
    queue_result_t batch[$];
    queue_result_t r;
    idx_t          p;
    case (m)
      MODE_ENQ: begin
        if (is_empty) begin
          head_idx = '0;
          tail_idx = '0;
          ring[0]  = w;
          is_empty = 1'b0;
          expected_results.push_back(lone_result(ST_OK, '0));
        end else if (ring_step(tail_idx) == head_idx) begin
          expected_results.push_back(lone_result(ST_OVERFLOW, '0));
        end else begin
          tail_idx       = ring_step(tail_idx);
          ring[tail_idx] = w;
          expected_results.push_back(lone_result(ST_OK, '0));
        end
      end
      MODE_DEQ: begin
        if (is_empty) begin
          expected_results.push_back(lone_result(ST_EMPTY, '0));
        end else begin
          expected_results.push_back(lone_result(ST_OK, ring[head_idx]));
          if (head_idx == tail_idx) begin
            is_empty = 1'b1;
            head_idx = '0;
            tail_idx = '0;
          end else begin
            head_idx = ring_step(head_idx);
          end
        end
      end
      default: begin
        if (is_empty) begin
          expected_results.push_back(lone_result(ST_EMPTY, '0));
        end else begin
          p = head_idx;
          for (int k = 0; k < DEPTH; k++) begin
            if (m == MODE_DISPLAY || ring[p] == w) begin
              r.status = (m == MODE_DISPLAY) ? ST_ELEMENT : ST_FOUND;
              r.slot   = SLOT_W'(p);
              r.word   = ring[p];
              r.last   = 1'b0;
              batch.push_back(r);
            end
            if (p == tail_idx) break;
            p = ring_step(p);
          end
          if (batch.size() == 0) begin
            expected_results.push_back(lone_result(ST_NOT_FOUND, '0));
          end else begin
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[j]) expected_results.push_back(batch[j]);
          end
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (!rst_n) begin
      expected_results.delete();
      head_idx    = '0;
      tail_idx    = '0;
      is_empty    = 1'b1;
      mismatches  = 0;
      outstanding = 0;
    end else begin
      // results always trail their request
      if (res_mon.valid && res_mon.ready) begin
        got.status = status_t'(res_mon.status);
        got.slot   = res_mon.slot;
        got.word   = res_mon.word_out;
        got.last   = res_mon.last;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result, actual status %0d slot %0d word %0d last %0d",
                   $time, got.status, got.slot, got.word, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.word !== want.word || got.last !== want.last) begin
            mismatches++;
            $display("%0t: expected status %0d slot %0d word %0d last %0d", $time,
                     want.status, want.slot, want.word, want.last);
            $display("%0t:   actual status %0d slot %0d word %0d last %0d", $time,
                     got.status, got.slot, got.word, got.last);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_queue_op(mode_t'(req_mon.mode), req_mon.data_word);
      end
      outstanding = expected_results.size();
    end
  end

endmodule

// ===== bench/circular_queue_with_search_unit_test.sv =====
`timescale 1ns / 1ps
module circular_queue_with_search_unit_test;
  import cqs_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 306;
  localparam int CALM_ITEMS   = 40;
  localparam int HOLD_CYCLES  = 90;
  localparam int HOLD_AT      = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatches;
  int unsigned outstanding;
  bit          calm = 1'b0;
  bit          hold_pending = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          burst_left = 0;

  logic signed [WORD_W-1:0] word_pool [4];

  cqs_in_if  req_ch();
  cqs_out_if res_ch();

  circular_queue_with_search_unit u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (req_ch),
    .out_if(res_ch)
  );

  queue_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (req_ch),
    .res_mon    (res_ch),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off, steady ready at the end
  always @(negedge clk) begin
    if (!rst_n) begin
      res_ch.ready = 1'b0;
    end else if (hold_pending && !hold_done) begin
      hold_done    = 1'b1;
      hold_left    = HOLD_CYCLES - 1;
      res_ch.ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ch.ready = 1'b0;
    end else if (calm) begin
      res_ch.ready = 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      res_ch.ready = 1'b0;
      burst_left   = $urandom_range(0, 10);
    end else begin
      res_ch.ready = 1'b1;
      burst_left   = $urandom_range(0, 15);
    end
  end

  task automatic offer_request(input mode_t m, input logic signed [WORD_W-1:0] w);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid     = 1'b0;
      req_ch.mode      = 2'($urandom_range(0, 3));
      req_ch.data_word = $urandom;
    end
    @(negedge clk);
    req_ch.valid     = 1'b1;
    req_ch.mode      = m;
    req_ch.data_word = w;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  initial begin
    int                       fill_bias;
    int                       roll;
    mode_t                    m;
    logic signed [WORD_W-1:0] w;
    req_ch.valid     = 1'b0;
    req_ch.mode      = MODE_ENQ;
    req_ch.data_word = '0;
    word_pool[0] = 32'sh7FFFFFFF;
    word_pool[1] = $urandom;
    word_pool[2] = $urandom;
    word_pool[3] = 32'sh80000000;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // requests on an empty queue
    offer_request(MODE_DEQ, '0);
    offer_request(MODE_SEARCH, 32'sd5);
    offer_request(MODE_DISPLAY, '0);
    // single word: found, then removed so the queue empties again
    offer_request(MODE_ENQ, 32'sd42);
    offer_request(MODE_SEARCH, 32'sd42);
    offer_request(MODE_DEQ, '0);
    // fill to the brim, then overflow
    offer_request(MODE_ENQ, 32'sh80000000);
    offer_request(MODE_ENQ, 32'sh7FFFFFFF);
    offer_request(MODE_ENQ, 32'sh00000000);
    offer_request(MODE_ENQ, -32'sd1);
    offer_request(MODE_ENQ, 32'sh55555555);
    offer_request(MODE_ENQ, 32'shAAAAAAAA);
    offer_request(MODE_ENQ, 32'sh7FFFFFFF);
    offer_request(MODE_ENQ, 32'sd1);
    offer_request(MODE_ENQ, 32'sd77);
    offer_request(MODE_SEARCH, 32'sh7FFFFFFF);
    offer_request(MODE_SEARCH, 32'sd12345);
    offer_request(MODE_DISPLAY, '0);
    // move head off zero and wrap the tail
    offer_request(MODE_DEQ, '0);
    offer_request(MODE_DEQ, '0);
    offer_request(MODE_ENQ, -32'sd5);
    offer_request(MODE_ENQ, 32'sh7FFFFFFF);
    offer_request(MODE_DISPLAY, '0);
    offer_request(MODE_SEARCH, 32'sh7FFFFFFF);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (i == HOLD_AT) hold_pending = 1'b1;
      // alternate fill-heavy and drain-heavy stretches
      fill_bias = ((i / 30) % 2 == 0) ? 6 : 2;
      roll = $urandom_range(0, 9);
      if (roll < fill_bias) begin
        m = MODE_ENQ;
      end else if (roll < 7) begin
        m = MODE_DEQ;
      end else if (roll < 9) begin
        m = MODE_SEARCH;
      end else begin
        m = MODE_DISPLAY;
      end
      // pool words make duplicates and search hits likely
      if ($urandom_range(0, 2) != 0) begin
        w = word_pool[$urandom_range(0, 3)];
      end else begin
        w = $urandom;
      end
      offer_request(m, w);
    end

    @(negedge clk);
    req_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DEPTH + 6) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cqs_pkg.sv
rtl/core/cqs_in_if.sv
rtl/core/cqs_out_if.sv
rtl/core/cqs_ram.sv
rtl/core/circular_queue_with_search_unit.sv
bench/queue_result_checker.sv
bench/circular_queue_with_search_unit_test.sv
